// File: hw/rtl/rslm_pkg.sv
// ---------------------------------------------------------------------------
// rslm_pkg: shared types and constants of the RMS sound level meter
// Default parameters, register codes, reset values and the log2 table.
// ---------------------------------------------------------------------------
package rslm_pkg;

   localparam int BLOCK_SAMPLES_DEF = 16;
   localparam int SAMPLE_BITS_DEF   = 12;

   // result fields are unsigned Q7.8 dB
   localparam int LEVEL_W = 15;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int DB_W       = 7;
   localparam int GAIN_W     = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_REFERENCE_LEVEL = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_OFFSET     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FLOOR_LEVEL     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CEILING_LEVEL   = 2'd3;

   localparam logic [DB_W-1:0]   REFERENCE_LEVEL_RST = 7'd94;
   localparam logic [GAIN_W-1:0] GAIN_OFFSET_RST     = 16'hC763;  // -14493
   localparam logic [DB_W-1:0]   FLOOR_LEVEL_RST     = 7'd40;
   localparam logic [DB_W-1:0]   CEILING_LEVEL_RST   = 7'd99;

   localparam logic [LEVEL_W-1:0] HELD_MIN_RST = 15'd25600;  // 100 dB
   localparam logic [LEVEL_W-1:0] HELD_MAX_RST = 15'd0;

   // 10*log10(2) in Q8
   localparam logic [9:0] LOG_SCALE = 10'd771;

   localparam int QUEUE_DEPTH = 2;

   // round(256*log2(1+i/64))
   localparam logic [7:0] LOG2_FRAC [64] = '{
      8'd0,   8'd6,   8'd11,  8'd17,  8'd22,  8'd28,  8'd33,  8'd38,
      8'd44,  8'd49,  8'd54,  8'd59,  8'd63,  8'd68,  8'd73,  8'd78,
      8'd82,  8'd87,  8'd92,  8'd96,  8'd100, 8'd105, 8'd109, 8'd113,
      8'd118, 8'd122, 8'd126, 8'd130, 8'd134, 8'd138, 8'd142, 8'd146,
      8'd150, 8'd154, 8'd157, 8'd161, 8'd165, 8'd169, 8'd172, 8'd176,
      8'd179, 8'd183, 8'd186, 8'd190, 8'd193, 8'd197, 8'd200, 8'd203,
      8'd207, 8'd210, 8'd213, 8'd216, 8'd220, 8'd223, 8'd226, 8'd229,
      8'd232, 8'd235, 8'd238, 8'd241, 8'd244, 8'd247, 8'd250, 8'd253
   };

   typedef struct packed {
      logic [DB_W-1:0]   reference_level;
      logic [GAIN_W-1:0] gain_offset;
      logic [DB_W-1:0]   floor_level;
      logic [DB_W-1:0]   ceiling_level;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// File: hw/rtl/rslm_front.sv
// ---------------------------------------------------------------------------
// rslm_front: sample squaring and block accumulation
// Squares each accepted sample, sums one block and pushes the sum.
// ---------------------------------------------------------------------------
module rslm_front #(
   parameter int BLOCK_SAMPLES = rslm_pkg::BLOCK_SAMPLES_DEF,
   parameter int SAMPLE_BITS   = rslm_pkg::SAMPLE_BITS_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_push,
   output logic                         req_full,
   input  logic [SAMPLE_BITS-1:0]       req_sample,
   input  rslm_pkg::q_status_type       q_status,
   output logic                         q_push,
   output logic [2*SAMPLE_BITS+$clog2(BLOCK_SAMPLES)-1:0] q_data
);
   import rslm_pkg::*;

   localparam int SQ_W  = 2 * SAMPLE_BITS;
   localparam int CW    = $clog2(BLOCK_SAMPLES);
   localparam int SUM_W = SQ_W + CW;

   logic [SQ_W-1:0]  sq_ff, sq_in;
   logic             sq_vld_ff, sq_vld_in;
   logic [SUM_W-1:0] acc_ff, acc_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             last, stall, accept;
   logic [SUM_W-1:0] sum_new;

   assign last     = (cnt_ff == CW'(BLOCK_SAMPLES - 1));
   // the closing sample of a block waits while the queue has no room
   assign stall    = sq_vld_ff && last && q_status.full;
   assign req_full = stall;
   assign accept   = req_push && !stall;
   assign sum_new  = acc_ff + SUM_W'(sq_ff);

   always_comb begin
      sq_vld_in = accept || stall;
      sq_in     = accept ? SQ_W'(SQ_W'(req_sample) * SQ_W'(req_sample)) : sq_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      q_push    = 1'b0;
      q_data    = sum_new;
      if (sq_vld_ff && !stall) begin
         if (last) begin
            q_push = 1'b1;
            acc_in = '0;
            cnt_in = '0;
         end else begin
            acc_in = sum_new;
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_vld_ff <= 1'b0;
         acc_ff    <= '0;
         cnt_ff    <= '0;
      end else begin
         sq_vld_ff <= sq_vld_in;
         acc_ff    <= acc_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      sq_ff <= sq_in;
   end

endmodule

// File: hw/rtl/rslm_queue.sv
// ---------------------------------------------------------------------------
// rslm_queue: short block-sum queue
// Small register queue between the accumulator and the level path.
// ---------------------------------------------------------------------------
module rslm_queue #(
   parameter int WIDTH = 28,
   parameter int DEPTH = rslm_pkg::QUEUE_DEPTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  logic [WIDTH-1:0]       wdata,
   input  logic                   pop,
   output logic [WIDTH-1:0]       rdata,
   output rslm_pkg::q_status_type status
);
   import rslm_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign rdata        = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

// File: hw/rtl/rslm_back.sv
// ---------------------------------------------------------------------------
// rslm_back: block level computation and min/max hold
// Mean square, log2 by normalization and table, dB scaling, clamp, hold.
// ---------------------------------------------------------------------------
module rslm_back #(
   parameter int BLOCK_SAMPLES = rslm_pkg::BLOCK_SAMPLES_DEF,
   parameter int SAMPLE_BITS   = rslm_pkg::SAMPLE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  rslm_pkg::cfg_type               cfg,
   input  rslm_pkg::q_status_type          q_status,
   output logic                            q_pop,
   input  logic [2*SAMPLE_BITS+$clog2(BLOCK_SAMPLES)-1:0] q_data,
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [rslm_pkg::LEVEL_W-1:0]    rsp_level_db,
   output logic [rslm_pkg::LEVEL_W-1:0]    rsp_min_db,
   output logic [rslm_pkg::LEVEL_W-1:0]    rsp_max_db,
   output logic [rslm_pkg::LEVEL_W-1:0]    rsp_avg_db
);
   import rslm_pkg::*;

   localparam int  MW     = 2 * SAMPLE_BITS;
   localparam int  LB     = $clog2(BLOCK_SAMPLES);
   localparam int  SUM_W  = MW + LB;
   localparam bit  POW2   = ((1 << LB) == BLOCK_SAMPLES);
   localparam int  PW     = $clog2(MW);
   localparam int  L2_W   = PW + 8;
   localparam int  PROD_W = L2_W + 10;
   localparam int  DBT_W  = PROD_W - 8;
   localparam int  LV_W   = DBT_W + 4;

   // floor(sum / BLOCK_SAMPLES) as (sum * RECIP) >> RS, exact for every
   // sum below 2**SUM_W; the sum is fed in one byte per cycle, top first
   localparam int  DG_W   = 8;
   localparam int  ND     = (SUM_W + DG_W - 1) / DG_W;
   localparam int  DW     = ND * DG_W;
   localparam int  RS     = SUM_W + LB;
   localparam int  RM_W   = SUM_W + 1;
   localparam int  AW     = DW + RM_W;
   localparam int  DC_W   = $clog2(ND + 1);
   localparam logic [RM_W-1:0] RECIP =
      RM_W'(((64'd1 << RS) + 64'(BLOCK_SAMPLES) - 64'd1) / 64'(BLOCK_SAMPLES));

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_DIV  = 3'd1;
   localparam logic [2:0] ST_NORM = 3'd2;
   localparam logic [2:0] ST_SUM  = 3'd3;
   localparam logic [2:0] ST_OUT  = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [DW-1:0]       quo_ff, quo_in;
   logic [AW-1:0]       acc_ff, acc_in;
   logic [DC_W-1:0]     dcnt_ff, dcnt_in;
   logic [MW-1:0]       m_ff, m_in;
   logic [PW-1:0]       pos_ff, pos_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [LEVEL_W-1:0]  level_ff, level_in;
   logic [LEVEL_W-1:0]  min_ff, min_in;
   logic [LEVEL_W-1:0]  max_ff, max_in;
   logic                rsp_vld_ff, rsp_vld_in;
   logic [LEVEL_W-1:0]  rsp_level_ff, rsp_min_ff, rsp_max_ff, rsp_avg_ff;
   logic                rsp_load;

   // reciprocal multiply step
   logic [DG_W+RM_W-1:0] part;
   logic [AW-1:0]       acc_step;
   logic [MW-1:0]       mean_div, mean_pow2;

   // normalization
   logic                shift4, shift1;
   logic [L2_W-1:0]     l2;

   // level arithmetic
   logic signed [LV_W-1:0] lvl, lo, hi, lvl_c;
   logic [LEVEL_W-1:0]  new_min, new_max;
   logic [LEVEL_W:0]    mm_sum;
   logic                slot_free;

   assign part      = {{RM_W{1'b0}}, quo_ff[DW-1 -: DG_W]} * {{DG_W{1'b0}}, RECIP};
   assign acc_step  = {acc_ff[AW-DG_W-1:0], {DG_W{1'b0}}} + AW'(part);
   assign mean_div  = acc_step[RS +: MW];
   assign mean_pow2 = q_data[LB +: MW];

   assign shift4 = (m_ff[MW-1 -: 4] == 4'd0) && (pos_ff >= PW'(4));
   assign shift1 = !m_ff[MW-1] && (pos_ff != '0);
   assign l2     = {pos_ff, LOG2_FRAC[m_ff[MW-2 -: 6]]};

   assign lvl = LV_W'({cfg.reference_level, 8'd0})
              + {{(LV_W-GAIN_W){cfg.gain_offset[GAIN_W-1]}}, cfg.gain_offset}
              + LV_W'(prod_ff[PROD_W-1:8]);
   assign lo  = LV_W'({cfg.floor_level, 8'd0});
   assign hi  = LV_W'({cfg.ceiling_level, 8'd0});

   always_comb begin
      lvl_c = lvl;
      if (lvl_c <= lo) begin
         lvl_c = lo;
      end
      if (lvl_c >= hi) begin
         lvl_c = hi;
      end
   end

   assign new_max   = (level_ff > max_ff) ? level_ff : max_ff;
   assign new_min   = (level_ff < min_ff) ? level_ff : min_ff;
   assign mm_sum    = {1'b0, new_min} + {1'b0, new_max};
   assign slot_free = !rsp_vld_ff || rsp_pop;

   always_comb begin
      state_in = state_ff;
      quo_in   = quo_ff;
      acc_in   = acc_ff;
      dcnt_in  = dcnt_ff;
      m_in     = m_ff;
      pos_in   = pos_ff;
      prod_in  = prod_ff;
      level_in = level_ff;
      min_in   = min_ff;
      max_in   = max_ff;
      q_pop    = 1'b0;
      rsp_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!q_status.empty) begin
               q_pop  = 1'b1;
               pos_in = PW'(MW - 1);
               if (POW2) begin
                  m_in     = (mean_pow2 == '0) ? MW'(1) : mean_pow2;
                  state_in = ST_NORM;
               end else begin
                  quo_in   = DW'(q_data);
                  acc_in   = '0;
                  dcnt_in  = '0;
                  state_in = ST_DIV;
               end
            end
         end
         ST_DIV: begin
            quo_in  = {quo_ff[DW-DG_W-1:0], {DG_W{1'b0}}};
            acc_in  = acc_step;
            dcnt_in = dcnt_ff + 1'b1;
            if (dcnt_ff == DC_W'(ND - 1)) begin
               m_in     = (mean_div == '0) ? MW'(1) : mean_div;
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            if (shift4) begin
               m_in   = {m_ff[MW-5:0], 4'd0};
               pos_in = pos_ff - PW'(4);
            end else if (shift1) begin
               m_in   = {m_ff[MW-2:0], 1'b0};
               pos_in = pos_ff - 1'b1;
            end else begin
               prod_in  = PROD_W'(l2) * PROD_W'(LOG_SCALE);
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            level_in = lvl_c[LEVEL_W-1:0];
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (slot_free) begin
               rsp_load = 1'b1;
               min_in   = new_min;
               max_in   = new_max;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      if (rsp_load) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_pop) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         rsp_vld_ff <= 1'b0;
         min_ff     <= HELD_MIN_RST;
         max_ff     <= HELD_MAX_RST;
      end else begin
         state_ff   <= state_in;
         rsp_vld_ff <= rsp_vld_in;
         min_ff     <= min_in;
         max_ff     <= max_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff   <= quo_in;
      acc_ff   <= acc_in;
      dcnt_ff  <= dcnt_in;
      m_ff     <= m_in;
      pos_ff   <= pos_in;
      prod_ff  <= prod_in;
      level_ff <= level_in;
      if (rsp_load) begin
         rsp_level_ff <= level_ff;
         rsp_min_ff   <= new_min;
         rsp_max_ff   <= new_max;
         rsp_avg_ff   <= mm_sum[LEVEL_W:1];
      end
   end

   assign rsp_empty    = !rsp_vld_ff;
   assign rsp_level_db = rsp_level_ff;
   assign rsp_min_db   = rsp_min_ff;
   assign rsp_max_db   = rsp_max_ff;
   assign rsp_avg_db   = rsp_avg_ff;

endmodule

// File: hw/rtl/rms_sound_level_meter.sv
// ---------------------------------------------------------------------------
// rms_sound_level_meter: RMS sound level meter with min/max hold
// Block RMS of ADC samples, reported as clamped Q7.8 dB with held extremes.
// ---------------------------------------------------------------------------
// Usage:
//  - Samples enter on req_push/req_full/req_sample, at most one transaction
//    per cycle; every BLOCK_SAMPLES samples close a block.
//  - One result per block leaves on rsp_empty/rsp_pop: level, held min,
//    held max and their average, all unsigned Q7.8 dB.
//  - From the closing sample to its result: finish and queue the sum,
//    pick it up, 0 to 8 leading-one normalization steps at default
//    settings, then the scale multiply, the clamp and the result register.
//    A BLOCK_SAMPLES that is not a power of two adds one reciprocal step
//    per byte of the block sum.
//  - Throughput: one sample per cycle while the level path keeps up;
//    the two-entry sum queue absorbs jitter, and req_full rises only
//    when it is full.
//  - A stalled receiver holds the result register; the level path waits,
//    the queue fills and req_full stalls the closing sample of a block.
//  - Reset restores register defaults, empties all stages and sets held
//    min to 100 dB, held max to 0 dB. Write csr_* only with nothing in flight.
// ---------------------------------------------------------------------------
module rms_sound_level_meter #(
   parameter int BLOCK_SAMPLES = rslm_pkg::BLOCK_SAMPLES_DEF,
   parameter int SAMPLE_BITS   = rslm_pkg::SAMPLE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // sample transactions
   input  logic                            req_push,
   output logic                            req_full,
   input  logic [SAMPLE_BITS-1:0]          req_sample,
   // result transactions
   output logic                            rsp_empty,
   input  logic                            rsp_pop,
   output logic [rslm_pkg::LEVEL_W-1:0]    rsp_level_db,
   output logic [rslm_pkg::LEVEL_W-1:0]    rsp_min_db,
   output logic [rslm_pkg::LEVEL_W-1:0]    rsp_max_db,
   output logic [rslm_pkg::LEVEL_W-1:0]    rsp_avg_db,
   // configuration writes
   input  logic                            csr_write,
   input  logic [rslm_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [rslm_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import rslm_pkg::*;

   localparam int SUM_W = 2 * SAMPLE_BITS + $clog2(BLOCK_SAMPLES);

   cfg_type          cfg_ff, cfg_in;
   q_status_type     q_status;
   logic             q_push, q_pop;
   logic [SUM_W-1:0] q_wdata, q_rdata;

   // register file: out-of-range bits of the write data are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_REFERENCE_LEVEL: cfg_in.reference_level = csr_wdata[DB_W-1:0];
            CSR_GAIN_OFFSET:     cfg_in.gain_offset     = csr_wdata[GAIN_W-1:0];
            CSR_FLOOR_LEVEL:     cfg_in.floor_level     = csr_wdata[DB_W-1:0];
            CSR_CEILING_LEVEL:   cfg_in.ceiling_level   = csr_wdata[DB_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.reference_level <= REFERENCE_LEVEL_RST;
         cfg_ff.gain_offset     <= GAIN_OFFSET_RST;
         cfg_ff.floor_level     <= FLOOR_LEVEL_RST;
         cfg_ff.ceiling_level   <= CEILING_LEVEL_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // front: square and accumulate one block
   rslm_front #(
      .BLOCK_SAMPLES (BLOCK_SAMPLES),
      .SAMPLE_BITS   (SAMPLE_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_sample (req_sample),
      .q_status   (q_status),
      .q_push     (q_push),
      .q_data     (q_wdata)
   );

   // block sums waiting for the level path
   rslm_queue #(
      .WIDTH (SUM_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (q_push),
      .wdata  (q_wdata),
      .pop    (q_pop),
      .rdata  (q_rdata),
      .status (q_status)
   );

   // back: mean, log, dB, clamp, hold and result register
   rslm_back #(
      .BLOCK_SAMPLES (BLOCK_SAMPLES),
      .SAMPLE_BITS   (SAMPLE_BITS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .q_status     (q_status),
      .q_pop        (q_pop),
      .q_data       (q_rdata),
      .rsp_empty    (rsp_empty),
      .rsp_pop      (rsp_pop),
      .rsp_level_db (rsp_level_db),
      .rsp_min_db   (rsp_min_db),
      .rsp_max_db   (rsp_max_db),
      .rsp_avg_db   (rsp_avg_db)
   );

endmodule
